FILE: hdl/fps_pkg.sv
// fps_pkg: shared types and constants for the fenwick prefix sum table
// no dependencies; imported by fps_alu and fenwick_prefix_sum_table
package fps_pkg;

  localparam int CMD_W = 2;
  localparam int FLD_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic sub;
    sum_t a;
    sum_t b;
  } alu_req_t;

endpackage

FILE: hdl/fps_ram.sv
// fps_ram: generic single write port, single read port ram with registered read
// no dependencies
module fps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/fps_alu.sv
// fps_alu: shared 64-bit wrapping add/subtract unit
// depends on fps_pkg
module fps_alu
  import fps_pkg::*;
(
  input  alu_req_t req,
  output sum_t     result
);

  always_comb begin
    if (req.sub) begin
      result = req.a - req.b;
    end else begin
      result = req.a + req.b;
    end
  end

endmodule

FILE: hdl/fenwick_prefix_sum_table.sv
// fenwick_prefix_sum_table: top level, command sequencer around one ram and one adder
// depends on fps_pkg, fps_ram and fps_alu
//
// Binary indexed tree of 64-bit partial sums over positions 1 to DEPTH-1, one
// command word in and one result word out. All work goes through a single
// partial-sum ram (one read, one write per cycle) and one shared 64-bit adder,
// so the block takes one word at a time and drops in_tready while busy. An add
// reads and then writes each tree node it updates; a prefix sum reads one node
// per set bit of the end position; a range sum runs two such walks back to
// back; a rejected add or range sum goes straight to the result; a clear and
// every reset run a clearing pass over all DEPTH entries, one ram entry a
// cycle, during which no word is taken. A finished result sits in an output
// register, so the next command may be taken while it waits; that command's
// result is then held back until the waiting word has been taken.
module fenwick_prefix_sum_table
  import fps_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // index, range_end, value
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // sum
  output logic        out_tuser   // error
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = ((AW > FLD_W) ? AW : FLD_W) + 1;
  localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P  = PW'(DEPTH);
  localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ADD_RD = 3'd2;
  localparam logic [2:0] ST_ADD_WR = 3'd3;
  localparam logic [2:0] ST_SUM    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic             clr_cmd_r, clr_cmd_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic             pend_r, pend_nxt;
  logic             phase_r, phase_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [FLD_W-1:0] idx_r, idx_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  sum_t             acc_r, acc_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  sum_t             out_sum_r, out_sum_nxt;
  logic             out_err_r, out_err_nxt;

  logic [CMD_W-1:0] in_cmd;
  logic [FLD_W-1:0] in_index;
  logic [FLD_W-1:0] in_end;
  logic [VAL_W-1:0] in_value;
  logic [PW-1:0]    end_ext, end_sat, start_m1, start_sat, pos_lsb;
  logic             accept, out_free;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  sum_t             ram_wdata, ram_rdata;
  alu_req_t         alu_req;
  sum_t             alu_res;

  assign in_cmd   = in_tuser;
  assign in_index = in_tdata[9:0];
  assign in_end   = in_tdata[19:10];
  assign in_value = in_tdata[51:20];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign end_ext   = PW'(in_end);
  assign end_sat   = (end_ext > LAST_POS) ? LAST_POS : end_ext;
  assign start_m1  = PW'(idx_r) - PW'(1);
  assign start_sat = (start_m1 > LAST_POS) ? LAST_POS : start_m1;
  assign pos_lsb   = pos_r & (~pos_r + PW'(1));

  fps_ram #(
    .WIDTH(SUM_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fps_alu u_alu (
    .req   (alu_req),
    .result(alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    clr_cmd_nxt   = clr_cmd_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r[AW-1:0];
    ram_wdata     = alu_res;
    ram_re        = 1'b0;
    ram_raddr     = pos_r[AW-1:0];
    alu_req.sub   = 1'b0;
    alu_req.a     = ram_rdata;
    alu_req.b     = {{(SUM_W-VAL_W){val_r[VAL_W-1]}}, val_r};

    unique case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_ADR) begin
          clr_nxt   = '0;
          state_nxt = clr_cmd_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_cmd;
          idx_nxt     = in_index;
          val_nxt     = in_value;
          acc_nxt     = '0;
          err_nxt     = 1'b0;
          pend_nxt    = 1'b0;
          phase_nxt   = 1'b0;
          clr_cmd_nxt = 1'b0;
          unique case (in_cmd)
            CMD_ADD: begin
              pos_nxt = PW'(in_index);
              if (in_index == '0) begin
                err_nxt   = 1'b1;
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_ADD_RD;
              end
            end
            CMD_PREFIX: begin
              pos_nxt   = end_sat;
              state_nxt = ST_SUM;
            end
            CMD_RANGE: begin
              pos_nxt = end_sat;
              if (in_index == '0) begin
                err_nxt   = 1'b1;
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_SUM;
              end
            end
            CMD_CLEAR: begin
              clr_nxt     = '0;
              clr_cmd_nxt = 1'b1;
              state_nxt   = ST_CLR;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_ADD_RD: begin
        if (pos_r == '0 || pos_r >= DEPTH_P) begin
          state_nxt = ST_FIN;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_ADD_WR;
        end
      end
      ST_ADD_WR: begin
        ram_we    = 1'b1;
        pos_nxt   = pos_r + pos_lsb;
        state_nxt = ST_ADD_RD;
      end
      ST_SUM: begin
        alu_req.sub = phase_r;
        alu_req.a   = acc_r;
        alu_req.b   = ram_rdata;
        if (pend_r) begin
          acc_nxt = alu_res;
        end
        if (pos_r != '0) begin
          ram_re   = 1'b1;
          pos_nxt  = pos_r - pos_lsb;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (cmd_r == CMD_RANGE && !phase_r) begin
              phase_nxt = 1'b1;
              pos_nxt   = start_sat;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = err_r ? '0 : acc_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      clr_cmd_r   <= 1'b0;
      pend_r      <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      pend_r      <= pend_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    acc_r     <= acc_nxt;
    err_r     <= err_nxt;
    out_sum_r <= out_sum_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_err_r;

endmodule

FILE: hdl/fps_chk.sv
// fps_chk: port-level checks for fenwick_prefix_sum_table, bound to the top level
// depends on fenwick_prefix_sum_table
module fps_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  // stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // error words carry a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("error word with non-zero sum");

  // one command word at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word taken while previous command busy");

  // clearing pass follows reset
  a_rst_clr: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("ready straight after reset");

endmodule

bind fenwick_prefix_sum_table fps_chk u_fps_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

FILE: tb/tb.sv
// tb: self-checking bench for fenwick_prefix_sum_table, directed words then random traffic
// depends on fps_pkg and the fenwick_prefix_sum_table rtl; shadow tree predicts every result
class fenwick_shadow;
  localparam int DEPTH = 1024;

  fps_pkg::sum_t tree_nodes[DEPTH];
  fps_pkg::sum_t sum_queue[$];
  bit            error_queue[$];
  int            mismatch_count;

  function new();
    foreach (tree_nodes[i]) tree_nodes[i] = '0;
    mismatch_count = 0;
  endfunction

  function fps_pkg::sum_t prefix_to(int unsigned pos);
    fps_pkg::sum_t acc;
    acc = '0;
    if (pos > DEPTH - 1) pos = DEPTH - 1;
    while (pos != 0) begin
      acc += tree_nodes[pos];
      pos -= pos & (~pos + 1);
    end
    return acc;
  endfunction

  // work out the result of an accepted command word and update the shadow tree
  function void take_command(logic [1:0] cmd, logic [9:0] start_pos, logic [9:0] end_pos,
                             logic [31:0] amount);
    fps_pkg::sum_t total;
    fps_pkg::sum_t wide;
    int unsigned   pos;
    bit            err;
    total = '0;
    err = 1'b0;
    wide = {{32{amount[31]}}, amount};
    case (cmd)
      fps_pkg::CMD_ADD: begin
        if (start_pos == 0) begin
          err = 1'b1;
        end else begin
          pos = start_pos;
          while (pos != 0 && pos < DEPTH) begin
            tree_nodes[pos] += wide;
            pos += pos & (~pos + 1);
          end
        end
      end
      fps_pkg::CMD_PREFIX: begin
        total = prefix_to(end_pos);
      end
      fps_pkg::CMD_RANGE: begin
        if (start_pos == 0) err = 1'b1;
        else total = prefix_to(end_pos) - prefix_to(start_pos - 1);
      end
      default: begin
        foreach (tree_nodes[i]) tree_nodes[i] = '0;
      end
    endcase
    sum_queue.insert(sum_queue.size(), total);
    error_queue.insert(error_queue.size(), err);
  endfunction

  task report_mismatch(string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task check_word(fps_pkg::sum_t got_sum, bit got_err);
    fps_pkg::sum_t want_sum;
    bit            want_err;
    if (sum_queue.size() == 0) begin
      report_mismatch($sformatf("unexpected word sum=%h error=%b", got_sum, got_err));
    end else begin
      want_sum = sum_queue.pop_front();
      want_err = error_queue.pop_front();
      if (got_sum !== want_sum)
        report_mismatch($sformatf("sum %h, want %h", got_sum, want_sum));
      if (got_err !== want_err)
        report_mismatch($sformatf("error %b, want %b", got_err, want_err));
    end
  endtask

  function int outstanding();
    return sum_queue.size();
  endfunction
endclass

module tb;
  import fps_pkg::*;

  localparam int RANDOM_WORDS = 1300;
  localparam int CYCLE_LIMIT = 8000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // index, range_end, value, zero pad
  logic [1:0]  in_tuser = '0;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // sum
  logic        out_tuser;       // error

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  fenwick_shadow shadow = new();

  fenwick_prefix_sum_table uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_word(out_tdata, out_tuser);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  task send_word(logic [1:0] cmd, logic [9:0] start_pos, logic [9:0] end_pos,
                 logic [31:0] amount);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, amount, end_pos, start_pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.take_command(cmd, start_pos, end_pos, amount);
  endtask

  function logic [31:0] pick_amount();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4, 5: return 32'($urandom_range(200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  function logic [9:0] pick_pos();
    case ($urandom_range(11))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'd1;
      3: return 10'd512;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  task random_word();
    int          r;
    logic [1:0]  cmd;
    r = $urandom_range(99);
    if (r < 44) cmd = CMD_ADD;
    else if (r < 64) cmd = CMD_PREFIX;
    else if (r < 98) cmd = CMD_RANGE;
    else cmd = CMD_CLEAR;
    send_word(cmd, pick_pos(), pick_pos(), pick_amount());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty tree, then extremes of the amount and the positions
    send_word(CMD_PREFIX, 10'd0, 10'd0, 32'h0);
    send_word(CMD_PREFIX, 10'd1023, 10'd1023, 32'hffff_ffff);
    send_word(CMD_ADD, 10'd0, 10'd5, 32'h1234_5678);
    send_word(CMD_ADD, 10'd1, 10'd0, 32'h7fff_ffff);
    send_word(CMD_ADD, 10'd1023, 10'd0, 32'h8000_0000);
    send_word(CMD_ADD, 10'd512, 10'd1023, 32'hffff_ffff);
    send_word(CMD_ADD, 10'd1, 10'd0, 32'h7fff_ffff);
    send_word(CMD_ADD, 10'd700, 10'd3, 32'd99);
    send_word(CMD_RANGE, 10'd0, 10'd1023, 32'h0);
    send_word(CMD_PREFIX, 10'd7, 10'd0, 32'h5);
    send_word(CMD_PREFIX, 10'd0, 10'd511, 32'h0);
    send_word(CMD_PREFIX, 10'd0, 10'd512, 32'h0);
    send_word(CMD_PREFIX, 10'd0, 10'd1023, 32'h0);
    send_word(CMD_RANGE, 10'd1, 10'd1023, 32'hffff_ffff);
    send_word(CMD_RANGE, 10'd512, 10'd512, 32'h0);
    send_word(CMD_RANGE, 10'd1023, 10'd1023, 32'h0);
    // start beyond end gives the negated middle
    send_word(CMD_RANGE, 10'd900, 10'd300, 32'h0);
    send_word(CMD_CLEAR, 10'd1023, 10'd1023, 32'hffff_ffff);
    send_word(CMD_PREFIX, 10'd0, 10'd1023, 32'h0);
    send_word(CMD_ADD, 10'd1023, 10'd0, 32'h7fff_ffff);
    send_word(CMD_RANGE, 10'd1, 10'd1022, 32'h0);
    send_word(CMD_RANGE, 10'd1023, 10'd1023, 32'h0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int n = 0; n < RANDOM_WORDS / 4; n++) random_word();
    end

    in_tvalid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (shadow.mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
